### hw/rtl/rrqa_pkg.sv
// Package for the round-robin quota arbiter: command codes, owner and
// agent-vector types, the input item struct and the lowest-set-bit search.
// No dependencies.
package rrqa_pkg;

    localparam int AGENT_SPAN = 64;
    localparam int OWNER_W    = 7;

    typedef logic [OWNER_W-1:0]    t_owner;
    typedef logic [AGENT_SPAN-1:0] t_agent_vec;

    localparam t_owner NO_OWNER = 7'd64;

    typedef enum logic [1:0] {
        CMD_LINK    = 2'd0,
        CMD_UNLINK  = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_ACQUIRE = 2'd3
    } t_cmd;

    typedef enum logic {
        KIND_GLOBAL = 1'b0,
        KIND_THINK  = 1'b1
    } t_kind;

    typedef struct packed {
        t_cmd        cmd;
        logic [5:0]  agent;
        logic        is_bot;
        logic [1:0]  affinity;
        t_agent_vec  active_mask;
        logic [1:0]  frame_slot;
        t_kind       quota_kind;
        logic [31:0] level_time;
    } t_in_item;

    function automatic t_owner lowest_set(input t_agent_vec v);
        t_owner r;
        r = NO_OWNER;
        for (int i = AGENT_SPAN - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = OWNER_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/rrqa_pick.sv
// Round-robin pick: next eligible agent after the current owner, wrapping.
// Depends on rrqa_pkg.
module rrqa_pick (
    input  rrqa_pkg::t_agent_vec i_elig,
    input  rrqa_pkg::t_owner     i_owner,
    output rrqa_pkg::t_owner     o_owner
);
    import rrqa_pkg::*;

    t_agent_vec w_hi_mask;
    t_agent_vec w_lo_mask;
    t_owner     w_hi_pick;
    t_owner     w_lo_pick;

    genvar g;
    generate
        for (g = 0; g < AGENT_SPAN; g++) begin : g_mask
            assign w_hi_mask[g] = i_owner[OWNER_W-1] || (OWNER_W'(g) > i_owner);
            assign w_lo_mask[g] = !i_owner[OWNER_W-1] && (OWNER_W'(g) < i_owner);
        end
    endgenerate

    assign w_hi_pick = lowest_set(i_elig & w_hi_mask);
    assign w_lo_pick = lowest_set(i_elig & w_lo_mask);

    always_comb begin
        if (w_hi_pick != NO_OWNER) begin
            o_owner = w_hi_pick;
        end else if (w_lo_pick != NO_OWNER) begin
            o_owner = w_lo_pick;
        end else begin
            o_owner = i_owner;
        end
    end

endmodule

### hw/rtl/round_robin_quota_arbiter_unit.sv
// Round-robin quota arbiter, top level: input register, agent table, quota
// owners and grant times, result register. Depends on rrqa_pkg, rrqa_pick.
//
// One item in, one result out, one item per cycle sustained while results
// are taken. A result is offered once its item has passed the input register
// and the result register; it can be taken at the following edge. The path
// between the two registers is set by the 64-agent rotating priority encoder
// that moves the global and the think owner on a frame tick. While a result
// waits to be taken, the block accepts one more item into its input register
// and then holds its input until the result is taken. Owner value 64 means
// no owner. Agents at or above MAX_AGENTS are ignored; only think slots
// reachable from a two-bit frame slot are stored.
module round_robin_quota_arbiter_unit #(
    parameter int MAX_AGENTS     = 64,
    parameter int AFFINITY_SLOTS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: agent[5:0], is_bot, affinity[1:0], active_mask[63:0],
    // frame_slot[1:0], quota_kind, level_time[31:0], zero pad
    input  logic [111:0] s_axis_tdata,
    // tuser from bit 0: cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: granted, global_owner[6:0], think_owner[6:0], zero pad
    output logic [15:0]  m_axis_tdata
);
    import rrqa_pkg::*;

    localparam int NA = (MAX_AGENTS < AGENT_SPAN) ? MAX_AGENTS : AGENT_SPAN;
    localparam int AW = $clog2(NA);
    localparam int NS = (AFFINITY_SLOTS < 4) ? AFFINITY_SLOTS : 4;
    localparam int SW = (NS > 1) ? $clog2(NS) : 1;
    localparam logic [2:0] NS3 = 3'(NS);
    localparam logic [OWNER_W-1:0] NA_OWN = OWNER_W'(NA);

    function automatic logic [SW-1:0] slot_reduce(input logic [1:0] f);
        logic [2:0] v;
        v = {1'b0, f};
        for (int k = 0; k < 3; k++) begin
            if (v >= NS3) begin
                v = v - NS3;
            end
        end
        return SW'(v);
    endfunction

    logic            r_iv;
    t_in_item        r_in;
    logic            r_ov;
    logic            r_out_granted;
    t_owner          r_out_go;
    t_owner          r_out_to;

    logic [NA-1:0]   r_present, n_present;
    logic [NA-1:0]   r_bot, n_bot;
    logic [1:0]      r_aff [NA];
    t_owner          r_gh, n_gh;
    t_owner          r_th [NS];
    t_owner          n_th [NS];
    logic            r_gv, n_gv;
    logic [31:0]     r_gt, n_gt;
    logic [NS-1:0]   r_tv, n_tv;
    logic [31:0]     r_tt [NS];
    logic [31:0]     n_tt [NS];
    logic [SW-1:0]   r_slot, n_slot;

    logic            w_adv;
    logic            w_ok;
    logic [AW-1:0]   w_idx;
    t_owner          w_agent_own;
    logic [SW-1:0]   w_tick_slot;
    t_agent_vec      w_gelig;
    t_agent_vec      w_telig;
    t_owner          w_g_next;
    t_owner          w_t_next;
    logic            n_granted;

    assign w_adv         = r_iv && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_iv || w_adv;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_out_to, r_out_go, r_out_granted};

    assign w_agent_own = {1'b0, r_in.agent};
    assign w_ok        = w_agent_own < NA_OWN;
    assign w_idx       = r_in.agent[AW-1:0];
    assign w_tick_slot = slot_reduce(r_in.frame_slot);

    genvar g;
    generate
        for (g = 0; g < AGENT_SPAN; g++) begin : g_elig
            if (g < NA) begin : g_in
                assign w_gelig[g] = r_present[g] && r_in.active_mask[g];
                assign w_telig[g] = w_gelig[g] && r_bot[g]
                                    && (r_aff[g] == 2'(w_tick_slot));
            end else begin : g_out
                assign w_gelig[g] = 1'b0;
                assign w_telig[g] = 1'b0;
            end
        end
    endgenerate

    rrqa_pick u_pick_global (
        .i_elig  (w_gelig),
        .i_owner (r_gh),
        .o_owner (w_g_next)
    );

    rrqa_pick u_pick_think (
        .i_elig  (w_telig),
        .i_owner (r_th[w_tick_slot]),
        .o_owner (w_t_next)
    );

    always_comb begin
        n_present = r_present;
        n_bot     = r_bot;
        n_gh      = r_gh;
        n_th      = r_th;
        n_gv      = r_gv;
        n_gt      = r_gt;
        n_tv      = r_tv;
        n_tt      = r_tt;
        n_slot    = r_slot;
        n_granted = 1'b0;
        case (r_in.cmd)
            CMD_LINK: begin
                if (w_ok) begin
                    n_present[w_idx] = 1'b1;
                    n_bot[w_idx]     = r_in.is_bot;
                end
            end
            CMD_UNLINK: begin
                if (w_ok) begin
                    n_present[w_idx] = 1'b0;
                    n_bot[w_idx]     = 1'b0;
                    if (r_gh == w_agent_own) begin
                        n_gh = NO_OWNER;
                    end
                    for (int s = 0; s < NS; s++) begin
                        if (r_th[s] == w_agent_own) begin
                            n_th[s] = NO_OWNER;
                        end
                    end
                end
            end
            CMD_TICK: begin
                n_slot              = w_tick_slot;
                n_gh                = w_g_next;
                n_th[w_tick_slot]   = w_t_next;
            end
            CMD_ACQUIRE: begin
                if (w_ok) begin
                    if (r_in.quota_kind == KIND_GLOBAL) begin
                        if (r_gh == w_agent_own && !(r_gv && r_gt == r_in.level_time)) begin
                            n_granted = 1'b1;
                            n_gv      = 1'b1;
                            n_gt      = r_in.level_time;
                        end
                    end else begin
                        if (r_th[r_slot] == w_agent_own
                            && !(r_tv[r_slot] && r_tt[r_slot] == r_in.level_time)) begin
                            n_granted      = 1'b1;
                            n_tv[r_slot]   = 1'b1;
                            n_tt[r_slot]   = r_in.level_time;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv      <= 1'b0;
            r_ov      <= 1'b0;
            r_present <= '0;
            r_bot     <= '0;
            r_gh      <= NO_OWNER;
            r_gv      <= 1'b0;
            r_tv      <= '0;
            r_slot    <= '0;
            for (int s = 0; s < NS; s++) begin
                r_th[s] <= NO_OWNER;
            end
        end else begin
            if (s_axis_tready) begin
                r_iv <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_ov      <= 1'b1;
                r_present <= n_present;
                r_bot     <= n_bot;
                r_gh      <= n_gh;
                r_th      <= n_th;
                r_gv      <= n_gv;
                r_tv      <= n_tv;
                r_slot    <= n_slot;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.cmd         <= t_cmd'(s_axis_tuser);
            r_in.agent       <= s_axis_tdata[5:0];
            r_in.is_bot      <= s_axis_tdata[6];
            r_in.affinity    <= s_axis_tdata[8:7];
            r_in.active_mask <= s_axis_tdata[72:9];
            r_in.frame_slot  <= s_axis_tdata[74:73];
            r_in.quota_kind  <= t_kind'(s_axis_tdata[75]);
            r_in.level_time  <= s_axis_tdata[107:76];
        end
        if (w_adv) begin
            r_gt          <= n_gt;
            r_tt          <= n_tt;
            r_out_granted <= n_granted;
            r_out_go      <= n_gh;
            r_out_to      <= n_th[n_slot];
            if (r_in.cmd == CMD_LINK && w_ok) begin
                r_aff[w_idx] <= r_in.affinity;
            end
        end
    end

    a_owner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gh != NO_OWNER) |-> (r_gh < NA_OWN))
        else $error("global owner outside agent range");

    a_link_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.cmd == CMD_LINK && w_ok) |=> r_present[$past(w_idx)])
        else $error("linked agent not present");

    a_unlink_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.cmd == CMD_UNLINK && w_ok) |=> (r_gh != $past(w_agent_own)))
        else $error("unlinked agent still owns global quota");

    a_grant_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_granted) |-> (r_in.cmd == CMD_ACQUIRE && w_ok))
        else $error("grant on a non-acquire item");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

### test/rrqa_owner_check.sv
// Owner and grant checker for the round-robin quota arbiter: tracks the agent
// table and both quota levels from accepted items, checks every result item.
// Depends on rrqa_pkg.
module rrqa_owner_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [111:0] i_in_data,
    input  logic [1:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [15:0]  i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    import rrqa_pkg::*;

    typedef struct packed {
        t_owner think_owner;
        t_owner global_owner;
        logic   granted;
    } t_owner_view;

    t_owner_view owners_due[$];

    t_agent_vec  seat_present;
    t_agent_vec  seat_bot;
    logic [1:0]  seat_aff [AGENT_SPAN];
    t_owner      glob_owner;
    t_owner      think_own [4];
    logic        glob_stamp_ok;
    logic [31:0] glob_stamp;
    logic        think_stamp_ok [4];
    logic [31:0] think_stamp [4];
    logic [1:0]  cur_slot;

    function automatic t_owner next_owner(input t_owner cur, input t_agent_vec elig);
        t_owner pick;
        int     idx;
        pick = cur;
        if (cur == NO_OWNER) begin
            for (int i = AGENT_SPAN - 1; i >= 0; i--) begin
                if (elig[i]) pick = t_owner'(i);
            end
        end else begin
            for (int j = AGENT_SPAN - 1; j >= 1; j--) begin
                idx = (int'(cur) + j) % AGENT_SPAN;
                if (elig[idx]) pick = t_owner'(idx);
            end
        end
        return pick;
    endfunction

    task automatic clear_table();
        seat_present = '0;
        seat_bot     = '0;
        glob_owner   = NO_OWNER;
        glob_stamp_ok = 1'b0;
        glob_stamp   = '0;
        cur_slot     = '0;
        for (int i = 0; i < AGENT_SPAN; i++) seat_aff[i] = '0;
        for (int s = 0; s < 4; s++) begin
            think_own[s]      = NO_OWNER;
            think_stamp_ok[s] = 1'b0;
            think_stamp[s]    = '0;
        end
    endtask

    task automatic predict_owners(input t_cmd cmd, input logic [111:0] d);
        logic [5:0]  agent;
        t_agent_vec  active;
        t_agent_vec  think_elig;
        logic [31:0] lt;
        t_owner      holder;
        logic        stamp_ok;
        logic [31:0] stamp;
        logic        granted;
        t_owner_view want;
        agent   = d[5:0];
        active  = d[72:9];
        lt      = d[107:76];
        granted = 1'b0;
        case (cmd)
            CMD_LINK: begin
                seat_present[agent] = 1'b1;
                seat_bot[agent]     = d[6];
                seat_aff[agent]     = d[8:7];
            end
            CMD_UNLINK: begin
                seat_present[agent] = 1'b0;
                seat_bot[agent]     = 1'b0;
                if (glob_owner == t_owner'(agent)) glob_owner = NO_OWNER;
                for (int s = 0; s < 4; s++) begin
                    if (think_own[s] == t_owner'(agent)) think_own[s] = NO_OWNER;
                end
            end
            CMD_TICK: begin
                cur_slot = d[74:73];
                for (int i = 0; i < AGENT_SPAN; i++) begin
                    think_elig[i] = seat_present[i] && active[i] && seat_bot[i]
                                    && seat_aff[i] == cur_slot;
                end
                glob_owner = next_owner(glob_owner, seat_present & active);
                think_own[cur_slot] = next_owner(think_own[cur_slot], think_elig);
            end
            default: begin
                if (t_kind'(d[75]) == KIND_GLOBAL) begin
                    holder   = glob_owner;
                    stamp_ok = glob_stamp_ok;
                    stamp    = glob_stamp;
                end else begin
                    holder   = think_own[cur_slot];
                    stamp_ok = think_stamp_ok[cur_slot];
                    stamp    = think_stamp[cur_slot];
                end
                if (holder == t_owner'(agent) && !(stamp_ok && stamp == lt)) begin
                    granted = 1'b1;
                    if (t_kind'(d[75]) == KIND_GLOBAL) begin
                        glob_stamp_ok = 1'b1;
                        glob_stamp    = lt;
                    end else begin
                        think_stamp_ok[cur_slot] = 1'b1;
                        think_stamp[cur_slot]    = lt;
                    end
                end
            end
        endcase
        want.granted      = granted;
        want.global_owner = glob_owner;
        want.think_owner  = think_own[cur_slot];
        owners_due = {owners_due, want};
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_owner_view want;
        t_owner_view got;
        if (!i_rst_n) begin
            clear_table();
            owners_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[14:0];
                if (owners_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("result item with nothing expected: %h", i_out_data);
                    end
                end else begin
                    want = owners_due.pop_front();
                    check_field("granted", want.granted, got.granted);
                    check_field("global_owner", want.global_owner, got.global_owner);
                    check_field("think_owner", want.think_owner, got.think_owner);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_owners(t_cmd'(i_in_user), i_in_data);
            end
        end
        o_pending = owners_due.size();
    end

endmodule

### test/round_robin_quota_arbiter_unit_test.sv
// Testbench top for the round-robin quota arbiter: clock, reset, item stimulus
// with sender and receiver gaps, and the verdict.
// Depends on rrqa_pkg, round_robin_quota_arbiter_unit, rrqa_owner_check.
module round_robin_quota_arbiter_unit_test;
    import rrqa_pkg::*;

    localparam int LIMIT_CYCLES     = 200000;
    localparam int HOLD_CYCLES      = 300;
    localparam int TAIL_CYCLES      = 8;
    localparam int RANDOM_PER_PHASE = 600;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic [111:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tready = 1'b0;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic [15:0]  m_axis_tdata;

    int          send_gap_pct = 0;
    int          take_gap_pct = 0;
    int          stall_seq    = 0;
    int          fail_count;
    int          pending;
    t_owner      seen_gown    = NO_OWNER;
    t_owner      seen_town    = NO_OWNER;
    logic [5:0]  pool_base    = '0;
    logic [31:0] level_now    = '0;

    round_robin_quota_arbiter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rrqa_owner_check owner_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        int stall_seen;
        int hold_left;
        stall_seen = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (stall_seq != stall_seen) begin
                stall_seen = stall_seq;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= take_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            seen_gown <= m_axis_tdata[7:1];
            seen_town <= m_axis_tdata[14:8];
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [5:0] agent, input logic is_bot,
                             input logic [1:0] aff, input t_agent_vec active,
                             input logic [1:0] fslot, input t_kind kind,
                             input logic [31:0] lt);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, lt, kind, fslot, active, aff, is_bot, agent};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic t_agent_vec any_mask();
        return {$urandom, $urandom};
    endfunction

    task automatic link_agent(input logic [5:0] agent, input logic is_bot,
                              input logic [1:0] aff);
        send_item(CMD_LINK, agent, is_bot, aff, any_mask(), 2'($urandom),
                  t_kind'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic unlink_agent(input logic [5:0] agent);
        send_item(CMD_UNLINK, agent, 1'($urandom), 2'($urandom), any_mask(),
                  2'($urandom), t_kind'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic frame_tick(input t_agent_vec active, input logic [1:0] fslot);
        send_item(CMD_TICK, 6'($urandom), 1'($urandom), 2'($urandom), active, fslot,
                  t_kind'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic acquire(input logic [5:0] agent, input t_kind kind,
                           input logic [31:0] lt);
        send_item(CMD_ACQUIRE, agent, 1'($urandom), 2'($urandom), any_mask(),
                  2'($urandom), kind, lt);
    endtask

    task automatic random_item();
        int          pick;
        logic [5:0]  agent;
        t_agent_vec  mask;
        t_kind       kind;
        t_owner      seen;
        logic [31:0] lt;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) agent = 6'($urandom);
        else agent = pool_base + 6'($urandom_range(0, 7));
        if (pick < 18) begin
            link_agent(agent, 1'($urandom), 2'($urandom));
        end else if (pick < 25) begin
            unlink_agent(agent);
        end else if (pick < 55) begin
            case ($urandom_range(0, 9))
                0:       mask = '1;
                1:       mask = '0;
                2:       mask = any_mask();
                default: mask = ~(any_mask() & any_mask());
            endcase
            frame_tick(mask, 2'($urandom));
        end else begin
            kind = t_kind'($urandom_range(0, 1));
            seen = (kind == KIND_GLOBAL) ? seen_gown : seen_town;
            if ($urandom_range(0, 3) < 2 && seen != NO_OWNER) agent = seen[5:0];
            case ($urandom_range(0, 9))
                0:       lt = $urandom;
                1, 2, 3: begin
                    level_now++;
                    lt = level_now;
                end
                default: lt = level_now;
            endcase
            acquire(agent, kind, lt);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct <= 16;
        take_gap_pct <= 59;

        frame_tick('1, 2'd0);
        acquire(6'd0, KIND_GLOBAL, 32'd0);
        link_agent(6'd0, 1'b1, 2'd0);
        link_agent(6'd63, 1'b1, 2'd3);
        link_agent(6'd5, 1'b0, 2'd1);
        link_agent(6'd5, 1'b1, 2'd1);
        frame_tick('1, 2'd0);
        acquire(6'd0, KIND_GLOBAL, 32'd0);
        acquire(6'd0, KIND_GLOBAL, 32'd0);
        acquire(6'd0, KIND_GLOBAL, 32'hFFFF_FFFF);
        acquire(6'd0, KIND_THINK, 32'd0);
        acquire(6'd5, KIND_GLOBAL, 32'd1);
        frame_tick('1, 2'd3);
        frame_tick('0, 2'd3);
        frame_tick(64'd1 << 5, 2'd1);
        unlink_agent(6'd5);
        unlink_agent(6'd40);
        frame_tick('1, 2'd2);
        acquire(6'd63, KIND_THINK, 32'd2);
        frame_tick(64'd1, 2'd3);
        acquire(6'd63, KIND_THINK, 32'd5);
        acquire(6'd63, KIND_THINK, 32'd5);
        unlink_agent(6'd63);

        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct <= (phase == 0) ? 16 : (phase == 1) ? 59 : 0;
            take_gap_pct <= (phase == 0) ? 59 : (phase == 1) ? 16 : 0;
            pool_base = 6'($urandom);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == 2 && n == 150) stall_seq <= stall_seq + 1;
                random_item();
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/rrqa_pkg.sv
hw/rtl/rrqa_pick.sv
hw/rtl/round_robin_quota_arbiter_unit.sv
test/rrqa_owner_check.sv
test/round_robin_quota_arbiter_unit_test.sv
